### rtl/core/asd_pkg.sv
`timescale 1ns / 1ps

package asd_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS     = 24;
    localparam int THRESH_BITS     = 23;
    localparam int MODE_BITS       = 2;
    localparam int OUT_BITS        = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 23;

    // Defaults for the top-level parameters
    localparam int MARGIN_FRAMES_DEF    = 4;
    localparam int FRAME_COUNT_BITS_DEF = 32;

    // Register reset values (threshold is roughly -90 dBFS in Q1.23)
    localparam logic [THRESH_BITS-1:0] AMP_THRESHOLD_RST = THRESH_BITS'(265);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AMP_THRESHOLD = 2'd0,
        REG_TRIM_MODE     = 2'd1
    } asd_reg_t;

    typedef enum logic [MODE_BITS-1:0] {
        TRIM_START = 2'd0,
        TRIM_END   = 2'd1,
        TRIM_BOTH  = 2'd2
    } asd_mode_t;

    typedef enum logic [1:0] {
        ST_TRIMMED = 2'd0,
        ST_NONE    = 2'd1,
        ST_SILENT  = 2'd2
    } asd_status_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
        logic                          clip_end;
    } asd_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] keep_start;
        logic [OUT_BITS-1:0] keep_end;
        logic [1:0]          trim_status;
    } asd_out_t;

endpackage

### rtl/core/audio_silence_trim_detector_unit.sv
`timescale 1ns / 1ps
// An accepted clip-end word reaches its result word through the input register,
//   then the result register; it is held back only while the result is stalled.
// Throughput: one sample word per cycle unless a clip-end word waits on a stalled
//   result; the per-sample work is a magnitude compare plus a frame-counter increment.
// Reset (rst_n, async, active low): clip state cleared, registers to defaults.
module audio_silence_trim_detector_unit #(
    parameter int MARGIN_FRAMES    = asd_pkg::MARGIN_FRAMES_DEF,
    parameter int FRAME_COUNT_BITS = asd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample words
    input  logic                               item_valid,
    output logic                               item_ready,
    input  asd_pkg::asd_in_t                   item,
    // region words, one per clip
    output logic                               result_valid,
    input  logic                               result_ready,
    output asd_pkg::asd_out_t                  result,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [asd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [asd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int W = FRAME_COUNT_BITS;
    localparam int SB = asd_pkg::SAMPLE_BITS;

    // ---------------------------------------------------------------
    // Configuration registers; writes always taken at once.
    // ---------------------------------------------------------------
    logic [asd_pkg::THRESH_BITS-1:0] amp_threshold_reg;
    logic [asd_pkg::MODE_BITS-1:0]   trim_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_threshold_reg <= asd_pkg::AMP_THRESHOLD_RST;
            trim_mode_reg     <= asd_pkg::TRIM_BOTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                asd_pkg::REG_AMP_THRESHOLD:
                    amp_threshold_reg <= cfg_data[asd_pkg::THRESH_BITS-1:0];
                asd_pkg::REG_TRIM_MODE:
                    trim_mode_reg <= cfg_data[asd_pkg::MODE_BITS-1:0];
                default:
                    ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register. The stage moves on unless it holds a clip-end word
    // and the result register is still full and stalled.
    // ---------------------------------------------------------------
    logic             s1_valid_reg, s1_valid_next;
    asd_pkg::asd_in_t s1_item_reg;
    logic             advance;
    logic             out_valid_reg, out_valid_next;
    asd_pkg::asd_out_t out_data_reg;

    assign advance = s1_valid_reg
                   && (!s1_item_reg.clip_end || !out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_ready)
            s1_valid_next = item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
    end

    // ---------------------------------------------------------------
    // Per-sample work: magnitude (most negative value saturates), compare
    // against the threshold, then close the frame on frame or clip end.
    // ---------------------------------------------------------------
    logic [SB-1:0]   neg_sample;
    logic [SB-2:0]   mag;
    logic            loud_now;
    logic            loud_eff;
    logic            close;
    logic            mark;

    logic [W-1:0] frame_count_reg,      frame_count_next;
    logic         frame_is_loud_reg,    frame_is_loud_next;
    logic         first_loud_seen_reg,  first_loud_seen_next;
    logic [W-1:0] first_loud_frame_reg, first_loud_frame_next;
    logic         last_loud_seen_reg,   last_loud_seen_next;
    logic [W-1:0] last_loud_frame_reg,  last_loud_frame_next;
    logic [W-1:0] fc_inc;

    assign neg_sample = -s1_item_reg.sample;

    always_comb
    begin
        if (!s1_item_reg.sample[SB-1])
            mag = s1_item_reg.sample[SB-2:0];
        else if (s1_item_reg.sample == {1'b1, {(SB-1){1'b0}}})
            mag = '1;
        else
            mag = neg_sample[SB-2:0];
    end

    assign loud_now = (mag > amp_threshold_reg);
    assign loud_eff = frame_is_loud_reg || loud_now;
    assign close    = s1_item_reg.frame_end || s1_item_reg.clip_end;
    assign mark     = close && loud_eff;
    // counter sticks at all-ones; later frames share that index
    assign fc_inc   = (&frame_count_reg) ? frame_count_reg : frame_count_reg + W'(1);

    always_comb
    begin
        frame_is_loud_next    = close ? 1'b0 : loud_eff;
        frame_count_next      = close ? fc_inc : frame_count_reg;
        first_loud_seen_next  = first_loud_seen_reg || mark;
        first_loud_frame_next = (mark && !first_loud_seen_reg)
                              ? frame_count_reg : first_loud_frame_reg;
        last_loud_seen_next   = last_loud_seen_reg || mark;
        last_loud_frame_next  = mark ? frame_count_reg : last_loud_frame_reg;
    end

    // Region computed from the post-update record; clip end always closes
    // a frame, so the frame total is the incremented count.
    asd_pkg::asd_out_t region;

    asd_region #(
        .MARGIN_FRAMES    (MARGIN_FRAMES),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_region (
        .first_seen  (first_loud_seen_next),
        .first_frame (first_loud_frame_next),
        .last_frame  (last_loud_frame_next),
        .frame_total (frame_count_next),
        .mode        (trim_mode_reg),
        .region      (region)
    );

    // Clip record: cleared after each clip-end word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg      <= '0;
            frame_is_loud_reg    <= 1'b0;
            first_loud_seen_reg  <= 1'b0;
            first_loud_frame_reg <= '0;
            last_loud_seen_reg   <= 1'b0;
            last_loud_frame_reg  <= '0;
        end
        else if (advance)
        begin
            if (s1_item_reg.clip_end)
            begin
                frame_count_reg      <= '0;
                frame_is_loud_reg    <= 1'b0;
                first_loud_seen_reg  <= 1'b0;
                first_loud_frame_reg <= '0;
                last_loud_seen_reg   <= 1'b0;
                last_loud_frame_reg  <= '0;
            end
            else
            begin
                frame_count_reg      <= frame_count_next;
                frame_is_loud_reg    <= frame_is_loud_next;
                first_loud_seen_reg  <= first_loud_seen_next;
                first_loud_frame_reg <= first_loud_frame_next;
                last_loud_seen_reg   <= last_loud_seen_next;
                last_loud_frame_reg  <= last_loud_frame_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register: holds one region word until taken.
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && s1_item_reg.clip_end)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.clip_end)
            out_data_reg <= region;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

### rtl/core/asd_region.sv
`timescale 1ns / 1ps

// Keep-region and status from the loud-frame record at clip end.
module asd_region #(
    parameter int MARGIN_FRAMES    = asd_pkg::MARGIN_FRAMES_DEF,
    parameter int FRAME_COUNT_BITS = asd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                        first_seen,
    input  logic [FRAME_COUNT_BITS-1:0] first_frame,
    input  logic [FRAME_COUNT_BITS-1:0] last_frame,
    input  logic [FRAME_COUNT_BITS-1:0] frame_total,
    input  logic [asd_pkg::MODE_BITS-1:0] mode,
    output asd_pkg::asd_out_t           region
);

    localparam int W  = FRAME_COUNT_BITS;
    localparam int EW = FRAME_COUNT_BITS + 8;  // room for last + 1 + margin

    logic          do_start;
    logic          do_end;
    logic [W-1:0]  ks_base;
    logic [W-1:0]  ks;
    logic [EW-1:0] ke_base;
    logic [EW-1:0] ke_raw;
    logic [EW-1:0] n_ext;
    logic [W-1:0]  ke;
    asd_pkg::asd_status_t status;

    assign do_start = (mode != asd_pkg::TRIM_END);
    assign do_end   = (mode != asd_pkg::TRIM_START);
    assign n_ext    = EW'(frame_total);

    always_comb
    begin
        ks_base = do_start ? first_frame : '0;
        ks      = (ks_base < W'(MARGIN_FRAMES)) ? '0 : ks_base - W'(MARGIN_FRAMES);
        ke_base = do_end ? (EW'(last_frame) + EW'(1)) : n_ext;
        ke_raw  = ke_base + EW'(MARGIN_FRAMES);
        ke      = (ke_raw > n_ext) ? frame_total : ke_raw[W-1:0];

        if (!first_seen)
        begin
            ks     = '0;
            ke     = frame_total;
            status = asd_pkg::ST_SILENT;
        end
        else if (ks >= ke)
            status = asd_pkg::ST_SILENT;
        else if ((ks == '0) && (ke == frame_total))
            status = asd_pkg::ST_NONE;
        else
            status = asd_pkg::ST_TRIMMED;
    end

    assign region.keep_start  = asd_pkg::OUT_BITS'(ks);
    assign region.keep_end    = asd_pkg::OUT_BITS'(ke);
    assign region.trim_status = status;

endmodule

### rtl/core/asd_checker.sv
`timescale 1ns / 1ps

module asd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input asd_pkg::asd_out_t result
);

    // stalled region word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("region word changed while stalled");

    // a non-silent status always leaves a non-empty region
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.trim_status != asd_pkg::ST_SILENT)
        |-> result.keep_start < result.keep_end)
        else $error("empty region with non-silent status");

    // nothing to trim means the region starts at frame zero
    a_none_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.trim_status == asd_pkg::ST_NONE)
        |-> result.keep_start == '0)
        else $error("untrimmed clip with non-zero start");

endmodule

bind audio_silence_trim_detector_unit asd_checker u_asd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### tb/tb_audio_silence_trim_detector_unit.sv
`timescale 1ns / 1ps

module tb_audio_silence_trim_detector_unit;

    import asd_pkg::*;

    // Timing
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 6;     // lets the input and result registers drain
    localparam int WATCHDOG_LIMIT = 3000;  // covers the long result hold-off below
    localparam int HOLD_OFF       = 300;
    localparam int PHASE_WORDS    = 92;
    localparam int NUM_PHASES     = 8;

    // Block constants as instantiated (defaults)
    localparam int MARGIN  = MARGIN_FRAMES_DEF;
    localparam int FC_BITS = FRAME_COUNT_BITS_DEF;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [THRESH_BITS-1:0] THRESH_MAX = '1;

    // Register indexes with no register behind them, and the unused mode code
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 2'd3;
    localparam logic [MODE_BITS-1:0]      MODE_SPARE   = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      item_valid = 1'b0;
    logic                      item_ready;
    asd_in_t                   item = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    asd_out_t                  result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    always #(CLK_HALF) clk = ~clk;

    audio_silence_trim_detector_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: registers and per-clip tracking state
    // ------------------------------------------------------------------
    logic [THRESH_BITS-1:0] thr_reg  = AMP_THRESHOLD_RST;
    logic [MODE_BITS-1:0]   mode_reg = TRIM_BOTH;

    logic [FC_BITS-1:0] frames      = '0;
    bit                 frame_loud  = 1'b0;
    bit                 first_seen  = 1'b0;
    logic [FC_BITS-1:0] first_frame = '0;
    logic [FC_BITS-1:0] last_frame  = '0;

    asd_out_t region_q[$];       // kept regions still owed by the block
    int       mismatch_count = 0;

    // Idle rates in percent, per cycle
    int sender_gap_pct = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;      // set once to make the sink hold off
    int hold_left      = 0;

    asd_in_t clip_words[$];

    // Works out the kept region for a sample word; 1 when the word closes a clip.
    function automatic bit predict_keep_region(input asd_in_t w, output asd_out_t r);
        logic [SAMPLE_BITS-1:0] mag;
        logic [63:0]            n;
        logic [63:0]            ks;
        logic [63:0]            ke;
        bit                     trim_head;
        bit                     trim_tail;
        r = '0;
        // magnitude; the most negative code saturates
        if (w.sample == SAMPLE_MIN)
            mag = SAMPLE_MAX;
        else if (w.sample[SAMPLE_BITS-1])
            mag = ~w.sample + 1'b1;
        else
            mag = w.sample;
        if (mag > {1'b0, thr_reg})
            frame_loud = 1'b1;

        // clip end closes a partial frame too
        if (w.frame_end || w.clip_end) begin
            if (frame_loud) begin
                if (!first_seen) begin
                    first_seen  = 1'b1;
                    first_frame = frames;
                end
                last_frame = frames;
            end
            frame_loud = 1'b0;
            if (frames != '1)
                frames++;
        end

        if (!w.clip_end)
            return 1'b0;

        n         = 64'(frames);
        trim_head = (mode_reg != TRIM_END);    // unused code 3 trims both ends
        trim_tail = (mode_reg != TRIM_START);
        if (!first_seen) begin
            ks            = '0;
            ke            = n;
            r.trim_status = ST_SILENT;
        end
        else begin
            ks = trim_head ? 64'(first_frame) : 64'd0;
            ke = trim_tail ? 64'(last_frame) + 64'd1 : n;
            ks = (ks < MARGIN) ? 64'd0 : ks - MARGIN;
            ke = ke + MARGIN;
            if (ke > n)
                ke = n;
            if (ks >= ke)
                r.trim_status = ST_SILENT;
            else if (ks == 0 && ke == n)
                r.trim_status = ST_NONE;
            else
                r.trim_status = ST_TRIMMED;
        end
        r.keep_start = ks[OUT_BITS-1:0];
        r.keep_end   = ke[OUT_BITS-1:0];

        frames      = '0;
        frame_loud  = 1'b0;
        first_seen  = 1'b0;
        first_frame = '0;
        last_frame  = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sample generators, relative to the threshold currently programmed
    // ------------------------------------------------------------------
    function automatic logic [SAMPLE_BITS-1:0] any_sample();
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] quiet_sample();
        logic [SAMPLE_BITS-1:0] m;
        m = ($urandom_range(7) == 0) ? SAMPLE_BITS'(thr_reg)
                                     : SAMPLE_BITS'($urandom_range(int'(thr_reg), 0));
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] loud_sample();
        logic [SAMPLE_BITS-1:0] m;
        int unsigned            lo;
        if (thr_reg == THRESH_MAX)
            return any_sample();               // nothing can be loud here
        if ($urandom_range(15) == 0)
            return SAMPLE_MIN;
        lo = int'(thr_reg) + 1;
        m  = ($urandom_range(7) == 0) ? SAMPLE_BITS'(lo)
                                      : SAMPLE_BITS'($urandom_range(int'(SAMPLE_MAX), lo));
        return $urandom_range(1) ? -m : m;
    endfunction

    // Builds one clip into clip_words. Mostly quiet lead-in, loud body and
    // quiet tail; some all-quiet clips, some cut short mid-frame, some noise.
    task automatic make_clip();
        int kind;
        int chans;
        int lead;
        int body;
        int tail;
        int nfr;
        int len;
        int loud_ch;
        int cut;
        bit loud;
        asd_in_t w;
        clip_words.delete();
        kind  = $urandom_range(99);
        chans = ($urandom_range(3) == 0) ? $urandom_range(4, 3) : $urandom_range(2, 1);

        if (kind < 10) begin
            // noise: random samples, frame marks that ignore the channel count
            len = $urandom_range(30, 1);
            for (int i = 0; i < len; i++) begin
                w.sample    = any_sample();
                w.frame_end = ($urandom_range(2) == 0);
                w.clip_end  = (i == len - 1);
                clip_words.push_back(w);
            end
        end
        else begin
            lead = $urandom_range(6);
            tail = $urandom_range(6);
            body = (kind < 20) ? 0 : $urandom_range(5, 1);
            if ($urandom_range(19) == 0)
                lead += $urandom_range(25);
            if (lead + body + tail == 0)
                lead = 1;
            nfr = lead + body + tail;
            for (int f = 0; f < nfr; f++) begin
                loud = (f >= lead) && (f < lead + body) &&
                       (f == lead || f == lead + body - 1 || $urandom_range(2) != 0);
                loud_ch = $urandom_range(chans - 1);
                for (int c = 0; c < chans; c++) begin
                    w.sample    = (loud && c == loud_ch) ? loud_sample() : quiet_sample();
                    w.frame_end = (c == chans - 1);
                    w.clip_end  = (f == nfr - 1) && (c == chans - 1);
                    clip_words.push_back(w);
                end
            end
            // clip ends part-way through its last frame
            if (kind >= 90 && chans > 1) begin
                cut = $urandom_range(chans - 1, 1);
                repeat (cut) void'(clip_words.pop_back());
                w           = clip_words.pop_back();
                w.clip_end  = 1'b1;
                clip_words.push_back(w);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one sample word and holds it until taken. Valid is left high so
    // that back-to-back words need no second assignment in the same step.
    task automatic send_word(input asd_in_t w, input bit typed, input asd_out_t typed_want);
        asd_out_t region;
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (predict_keep_region(w, region))
            region_q.push_back(typed ? typed_want : region);
        while ($urandom_range(99) < sender_gap_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Register write; caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_AMP_THRESHOLD)
            thr_reg = data[THRESH_BITS-1:0];
        else if (idx == REG_TRIM_MODE)
            mode_reg = data[MODE_BITS-1:0];
    endtask

    // Waits for every owed region, then lets the pipeline empty.
    task automatic settle();
        while (region_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed words, under reset defaults (threshold 265, trim both).
    // Regions typed in where obvious; the rest come from the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        asd_in_t  w;
        logic     typed;
        asd_out_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // one quiet frame: whole clip silent
        '{'{24'sd0, 1'b1, 1'b1}, 1'b1, '{32'd0, 32'd1, ST_SILENT}},
        // most negative sample saturates and is loud
        '{'{-24'sd8388608, 1'b1, 1'b1}, 1'b1, '{32'd0, 32'd1, ST_NONE}},
        // clip end with no frame end still closes the frame
        '{'{24'sd8388607, 1'b0, 1'b1}, 1'b1, '{32'd0, 32'd1, ST_NONE}},
        // threshold edge: +/-265 quiet, 266 loud in frame 6 of 12
        '{'{24'sd265, 1'b1, 1'b0}, 1'b0, '0},
        '{'{-24'sd265, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{-24'sd1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd100, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd266, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd264, 1'b1, 1'b0}, 1'b0, '0},
        '{'{-24'sd264, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd2, 1'b1, 1'b0}, 1'b0, '0},
        '{'{-24'sd2, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd7, 1'b1, 1'b1}, 1'b1, '{32'd2, 32'd11, ST_TRIMMED}},
        // stereo, loud negative sample in the first frame
        '{'{-24'sd266, 1'b0, 1'b0}, 1'b0, '0},
        '{'{24'sd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{24'sd0, 1'b1, 1'b1}, 1'b0, '0},
        // stereo, loud sample in a partial last frame
        '{'{24'sd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{24'sd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{24'sd300, 1'b0, 1'b1}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request <= 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Region check against the oldest owed word
    always @(posedge clk) begin : region_check
        asd_out_t want;
        if (rst_n && result_valid && result_ready) begin
            if (region_q.size() == 0) begin
                $display("%0t: region word with none owed: start %0d end %0d status %0d",
                         $time, result.keep_start, result.keep_end, result.trim_status);
                mismatch_count++;
            end
            else begin
                want = region_q.pop_front();
                if (result.keep_start !== want.keep_start) begin
                    $display("%0t: keep_start expected %0d, got %0d",
                             $time, want.keep_start, result.keep_start);
                    mismatch_count++;
                end
                if (result.keep_end !== want.keep_end) begin
                    $display("%0t: keep_end expected %0d, got %0d",
                             $time, want.keep_end, result.keep_end);
                    mismatch_count++;
                end
                if (result.trim_status !== want.trim_status) begin
                    $display("%0t: trim_status expected %0d, got %0d",
                             $time, want.trim_status, result.trim_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on any channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [THRESH_BITS-1:0]   thr_pick;
        logic [MODE_BITS-1:0]     mode_pick;
        logic [CFG_DATA_BITS-1:0] mode_data;
        bit                       noisy_mode;
        int                       sent;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        sender_gap_pct = 18;
        sink_stall_pct = 60;
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
        item_valid <= 1'b0;
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // idle pattern: sender light / sink heavy, then swapped, then none
            sender_gap_pct = (p < 3) ? 18 : (p < 6) ? 60 : 0;
            sink_stall_pct = (p < 3) ? 60 : (p < 6) ? 18 : 0;

            noisy_mode = 1'b0;
            case (p)
                1: begin thr_pick = '0;                 mode_pick = TRIM_START; end
                2: begin thr_pick = THRESH_MAX;         mode_pick = TRIM_END;   end
                3: begin
                    thr_pick   = THRESH_BITS'($urandom);
                    mode_pick  = MODE_SPARE;
                    noisy_mode = 1'b1;
                end
                4: begin thr_pick = THRESH_BITS'($urandom_range(4095)); mode_pick = TRIM_END; end
                5: begin thr_pick = THRESH_BITS'($urandom); mode_pick = TRIM_START; end
                6: begin thr_pick = AMP_THRESHOLD_RST;  mode_pick = TRIM_BOTH;  end
                default: begin
                    thr_pick   = THRESH_BITS'($urandom);
                    mode_pick  = MODE_BITS'($urandom_range(3));
                    noisy_mode = 1'b1;
                end
            endcase

            if (p == 0) begin
                // writes to indexes with no register must change nothing
                write_reg(REG_UNUSED_A, CFG_DATA_BITS'($urandom));
                write_reg(REG_UNUSED_B, CFG_DATA_BITS'($urandom));
            end
            else begin
                // upper data bits of the mode write are don't-care
                mode_data = CFG_DATA_BITS'(mode_pick);
                if (noisy_mode)
                    mode_data = mode_data | (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(3));
                write_reg(REG_AMP_THRESHOLD, CFG_DATA_BITS'(thr_pick));
                write_reg(REG_TRIM_MODE, mode_data);
            end
            cfg_valid <= 1'b0;

            // sink holds off while words keep coming, so the block backs up
            if (p == 6)
                hold_request <= HOLD_OFF;

            sent = 0;
            while (sent < PHASE_WORDS) begin
                make_clip();
                foreach (clip_words[k])
                    send_word(clip_words[k], 1'b0, '0);
                sent += clip_words.size();
            end
            // every phase ends on a clip end; stop and let all regions arrive
            item_valid <= 1'b0;
            settle();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
